>>> hw/rtl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types, codes and helpers of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int VAL_W = 64;
   localparam int OP_W = 5;

   localparam logic [2:0] FUNC_OPERAND = 3'd0;
   localparam logic [2:0] FUNC_OPERATOR = 3'd1;
   localparam logic [2:0] FUNC_OPEN = 3'd2;
   localparam logic [2:0] FUNC_CLOSE = 3'd3;

   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_MOD = 4'd4;
   localparam logic [3:0] OP_GT = 4'd5;
   localparam logic [3:0] OP_GE = 4'd6;
   localparam logic [3:0] OP_LT = 4'd7;
   localparam logic [3:0] OP_LE = 4'd8;
   localparam logic [3:0] OP_EQ = 4'd9;
   localparam logic [3:0] OP_NE = 4'd10;
   localparam logic [3:0] OP_OR = 4'd11;
   localparam logic [3:0] OP_AND = 4'd12;

   localparam logic [OP_W-1:0] OPEN_MARK = 5'd16;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_PAREN = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_DIV0 = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   // request to the arithmetic unit
   typedef struct packed {
      logic             start;
      logic [3:0]       op;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic             done;
      logic             div0;
      logic [VAL_W-1:0] r;
   } alu_rsp_type;

   function automatic logic [2:0] prec_of(input logic [OP_W-1:0] op);
      logic [2:0] p;
      p = 3'd0;
      if (op >= 5'd2 && op <= 5'd4) p = 3'd5;
      else if (op <= 5'd1) p = 3'd4;
      else if (op >= 5'd5 && op <= 5'd8) p = 3'd3;
      else if (op == 5'd9 || op == 5'd10) p = 3'd2;
      else if (op == 5'd11 || op == 5'd12) p = 3'd1;
      return p;
   endfunction

endpackage

>>> hw/rtl/iee_alu.sv
// ----------------------------------------------------------------------------
// iee_alu
// Binary operator unit: registered add/sub/compare/logic, staged multiply,
// radix-2 divider for div and mod.
// ----------------------------------------------------------------------------
module iee_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  iee_pkg::alu_req_type req,
   output iee_pkg::alu_rsp_type rsp
);

   localparam int W = iee_pkg::VAL_W;
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL = 3'd1;
   localparam logic [2:0] S_MSUM = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_FIX = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic [W-1:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [W-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic done_ff, done_in, div0_ff, div0_in;
   logic [W-1:0] r_ff, r_in;

   logic lt, eq;
   logic [W:0] rem_sh, rem_sub;

   always_comb begin
      lt = $signed(req.a) < $signed(req.b);
      eq = req.a == req.b;
      rem_sh = {rem_ff, quo_ff[W-1]};
      rem_sub = rem_sh - {1'b0, b_ff};
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      a_in = a_ff;
      b_in = b_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      done_in = 1'b0;
      div0_in = 1'b0;
      r_in = r_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               op_in = req.op;
               a_in = req.a;
               b_in = req.b;
               done_in = 1'b1;
               case (req.op)
                  iee_pkg::OP_ADD: r_in = req.a + req.b;
                  iee_pkg::OP_SUB: r_in = req.a - req.b;
                  iee_pkg::OP_GT: r_in = W'(!lt && !eq);
                  iee_pkg::OP_GE: r_in = W'(!lt);
                  iee_pkg::OP_LT: r_in = W'(lt);
                  iee_pkg::OP_LE: r_in = W'(lt || eq);
                  iee_pkg::OP_EQ: r_in = W'(eq);
                  iee_pkg::OP_NE: r_in = W'(!eq);
                  iee_pkg::OP_OR: r_in = W'(req.a != '0 || req.b != '0);
                  iee_pkg::OP_AND: r_in = W'(req.a != '0 && req.b != '0);
                  iee_pkg::OP_MUL: begin
                     done_in = 1'b0;
                     state_in = S_MUL;
                  end
                  iee_pkg::OP_DIV, iee_pkg::OP_MOD: begin
                     if (req.b == '0) begin
                        div0_in = 1'b1;
                     end else begin
                        done_in = 1'b0;
                        a_in = req.a[W-1] ? -req.a : req.a;
                        b_in = req.b[W-1] ? -req.b : req.b;
                        quo_in = req.a[W-1] ? -req.a : req.a;
                        rem_in = '0;
                        cnt_in = 7'(W);
                        p0_in = {req.a[W-1], req.b[W-1], {(W-2){1'b0}}};
                        state_in = S_DIV;
                     end
                  end
                  default: r_in = '0;
               endcase
            end
         end
         S_MUL: begin
            // three 32x32 partial products, high x high drops out of 64 bits
            p0_in = W'(a_ff[31:0] * b_ff[31:0]);
            p1_in = W'(a_ff[63:32] * b_ff[31:0]);
            p2_in = W'(a_ff[31:0] * b_ff[63:32]);
            state_in = S_MSUM;
         end
         S_MSUM: begin
            r_in = p0_ff + {p1_ff[31:0] + p2_ff[31:0], 32'd0};
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV: begin
            if (!rem_sub[W]) rem_in = rem_sub[W-1:0];
            else rem_in = rem_sh[W-1:0];
            quo_in = {quo_ff[W-2:0], !rem_sub[W]};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) state_in = S_FIX;
         end
         S_FIX: begin
            if (op_ff == iee_pkg::OP_DIV) r_in = (p0_ff[W-1] ^ p0_ff[W-2]) ? -quo_ff : quo_ff;
            else r_in = p0_ff[W-1] ? -rem_ff : rem_ff;
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         div0_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in | div0_in;
         div0_ff <= div0_in;
      end
      op_ff <= op_in;
      a_ff <= a_in;
      b_ff <= b_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      r_ff <= r_in;
   end

   assign rsp.done = done_ff;
   assign rsp.div0 = div0_ff;
   assign rsp.r = r_ff;

endmodule

>>> hw/rtl/infix_expression_evaluator_top.sv
// Sequence: an operand or open paren passes S_TOKEN and S_FINAL before the next
// token is taken; an operator or close paren adds S_PEEK and S_DECIDE, plus
// S_VRD, S_VRD2, S_ALU and S_WAIT per operator applied. A last token adds its
// drain, S_RES and S_OUT. Throughput: one token at a time, set by the operator
// loop over the stack memories and the shared arithmetic unit.
// Reset: synchronous, clears counts and error state; stack memories keep
// their contents and need no clearing pass.
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top
// Shunting-yard evaluator with operator and value stacks in memories.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top #(
   parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] func, [6:3] op_code, [70:7] operand, zero fill to 72
   input  logic [71:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [63:0] value, [64] truth, [67:65] status, zero fill to 72
   output logic [71:0] rsp_tdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int W = iee_pkg::VAL_W;
   localparam int OW = iee_pkg::OP_W;
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TOKEN = 4'd1;
   localparam logic [3:0] S_PEEK = 4'd2;   // operator top read issued
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_VRD = 4'd4;    // value reads
   localparam logic [3:0] S_VRD2 = 4'd5;
   localparam logic [3:0] S_ALU = 4'd6;
   localparam logic [3:0] S_WAIT = 4'd7;
   localparam logic [3:0] S_FINAL = 4'd8;
   localparam logic [3:0] S_RES = 4'd9;
   localparam logic [3:0] S_OUT = 4'd10;

   logic [OW-1:0] ostk [STACK_DEPTH];
   logic [W-1:0] vstk [STACK_DEPTH];

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] ocnt_ff, ocnt_in, vcnt_ff, vcnt_in;
   logic [2:0] perr_ff, perr_in, eerr_ff, eerr_in;
   logic [2:0] func_ff, func_in;
   logic [3:0] opc_ff, opc_in;
   logic [W-1:0] opnd_ff, opnd_in;
   logic last_ff, last_in;
   logic drain_ff, drain_in;   // draining for last token
   logic [OW-1:0] cur_ff, cur_in;   // operator popped and in flight
   logic [W-1:0] va_ff, va_in;
   logic rsp_v_ff, rsp_v_in;
   logic [71:0] rsp_d_ff, rsp_d_in;

   logic o_we, v_we;
   logic [AW-1:0] o_wa, v_wa, o_ra, v_ra;
   logic [OW-1:0] o_wd;
   logic [W-1:0] v_wd;
   logic [OW-1:0] o_rd_ff;
   logic [W-1:0] v_rd_ff;

   iee_pkg::alu_req_type alu_req;
   iee_pkg::alu_rsp_type alu_rsp;

   iee_alu u_alu (
      .clock(clock),
      .reset(reset),
      .req(alu_req),
      .rsp(alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (o_we) ostk[o_wa] <= o_wd;
      if (v_we) vstk[v_wa] <= v_wd;
      o_rd_ff <= ostk[o_ra];
      v_rd_ff <= vstk[v_ra];
   end

   logic [W-1:0] status_val;

   always_comb begin
      state_in = state_ff;
      ocnt_in = ocnt_ff;
      vcnt_in = vcnt_ff;
      perr_in = perr_ff;
      eerr_in = eerr_ff;
      func_in = func_ff;
      opc_in = opc_ff;
      opnd_in = opnd_ff;
      last_in = last_ff;
      drain_in = drain_ff;
      cur_in = cur_ff;
      va_in = va_ff;
      rsp_v_in = rsp_v_ff;
      rsp_d_in = rsp_d_ff;
      o_we = 1'b0;
      v_we = 1'b0;
      o_wa = ocnt_ff[AW-1:0];
      v_wa = vcnt_ff[AW-1:0];
      o_wd = '0;
      v_wd = opnd_ff;
      o_ra = AW'(ocnt_ff - CW'(1));
      v_ra = AW'(vcnt_ff - CW'(1));
      alu_req.start = 1'b0;
      alu_req.op = cur_ff[3:0];
      alu_req.a = va_ff;
      alu_req.b = v_rd_ff;
      status_val = '0;
      req_tready = 1'b0;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in = req_tdata[2:0];
               opc_in = req_tdata[6:3];
               opnd_in = req_tdata[70:7];
               last_in = req_tlast;
               drain_in = 1'b0;
               state_in = S_TOKEN;
            end
         end
         S_TOKEN: begin
            state_in = S_FINAL;
            if (perr_ff == iee_pkg::ST_OK) begin
               case (func_ff)
                  iee_pkg::FUNC_OPERAND: begin
                     if (eerr_ff == iee_pkg::ST_OK) begin
                        if (vcnt_ff >= FULL) eerr_in = iee_pkg::ST_OVERFLOW;
                        else begin
                           v_we = 1'b1;
                           vcnt_in = vcnt_ff + CW'(1);
                        end
                     end
                  end
                  iee_pkg::FUNC_OPERATOR: begin
                     if (opc_ff > iee_pkg::OP_AND) perr_in = iee_pkg::ST_INVALID;
                     else state_in = S_PEEK;
                  end
                  iee_pkg::FUNC_OPEN: begin
                     if (ocnt_ff >= FULL) perr_in = iee_pkg::ST_OVERFLOW;
                     else begin
                        o_we = 1'b1;
                        o_wd = iee_pkg::OPEN_MARK;
                        ocnt_in = ocnt_ff + CW'(1);
                     end
                  end
                  iee_pkg::FUNC_CLOSE: state_in = S_PEEK;
                  default: perr_in = iee_pkg::ST_INVALID;
               endcase
            end
         end
         S_PEEK: state_in = S_DECIDE;   // read of operator top in flight
         S_DECIDE: begin
            if (drain_ff) begin
               if (perr_ff != iee_pkg::ST_OK || ocnt_ff == '0) state_in = S_RES;
               else if (o_rd_ff == iee_pkg::OPEN_MARK) begin
                  perr_in = iee_pkg::ST_PAREN;
                  state_in = S_RES;
               end else begin
                  cur_in = o_rd_ff;
                  ocnt_in = ocnt_ff - CW'(1);
                  state_in = S_VRD;
               end
            end else if (func_ff == iee_pkg::FUNC_OPERATOR) begin
               if (ocnt_ff != '0 && o_rd_ff != iee_pkg::OPEN_MARK &&
                   iee_pkg::prec_of(o_rd_ff) >= iee_pkg::prec_of({1'b0, opc_ff})) begin
                  cur_in = o_rd_ff;
                  ocnt_in = ocnt_ff - CW'(1);
                  state_in = S_VRD;
               end else begin
                  if (ocnt_ff >= FULL) perr_in = iee_pkg::ST_OVERFLOW;
                  else begin
                     o_we = 1'b1;
                     o_wd = {1'b0, opc_ff};
                     ocnt_in = ocnt_ff + CW'(1);
                  end
                  state_in = S_FINAL;
               end
            end else begin
               if (ocnt_ff == '0) begin
                  perr_in = iee_pkg::ST_PAREN;
                  state_in = S_FINAL;
               end else if (o_rd_ff == iee_pkg::OPEN_MARK) begin
                  ocnt_in = ocnt_ff - CW'(1);
                  state_in = S_FINAL;
               end else begin
                  cur_in = o_rd_ff;
                  ocnt_in = ocnt_ff - CW'(1);
                  state_in = S_VRD;
               end
            end
         end
         S_VRD: begin
            // apply the popped operator unless evaluation already failed or under two values remain
            if (eerr_ff != iee_pkg::ST_OK) state_in = S_PEEK;
            else if (vcnt_ff < CW'(2)) begin
               eerr_in = iee_pkg::ST_INVALID;
               state_in = S_PEEK;
            end else begin
               v_ra = AW'(vcnt_ff - CW'(2));
               state_in = S_VRD2;
            end
         end
         S_VRD2: begin
            va_in = v_rd_ff;
            state_in = S_ALU;
         end
         S_ALU: begin
            alu_req.start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (alu_rsp.done) begin
               if (alu_rsp.div0) eerr_in = iee_pkg::ST_DIV0;
               else begin
                  v_we = 1'b1;
                  v_wa = AW'(vcnt_ff - CW'(2));
                  v_wd = alu_rsp.r;
                  vcnt_in = vcnt_ff - CW'(1);
               end
               state_in = S_PEEK;
            end
         end
         S_FINAL: begin
            if (last_ff) begin
               drain_in = 1'b1;
               state_in = S_PEEK;
            end else state_in = S_IDLE;
         end
         S_RES: begin
            v_ra = '0;
            if (perr_ff == iee_pkg::ST_OK && eerr_ff == iee_pkg::ST_OK && vcnt_ff != CW'(1))
               eerr_in = iee_pkg::ST_INVALID;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_v_ff || rsp_tready) begin
               if (perr_ff != iee_pkg::ST_OK) rsp_d_in = {4'd0, perr_ff, 1'b0, 64'd0};
               else if (eerr_ff != iee_pkg::ST_OK) rsp_d_in = {4'd0, eerr_ff, 1'b0, 64'd0};
               else begin
                  status_val = v_rd_ff;
                  rsp_d_in = {4'd0, iee_pkg::ST_OK, status_val != '0, status_val};
               end
               rsp_v_in = 1'b1;
               ocnt_in = '0;
               vcnt_in = '0;
               perr_in = iee_pkg::ST_OK;
               eerr_in = iee_pkg::ST_OK;
               drain_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ocnt_ff <= '0;
         vcnt_ff <= '0;
         perr_ff <= iee_pkg::ST_OK;
         eerr_ff <= iee_pkg::ST_OK;
         drain_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ocnt_ff <= ocnt_in;
         vcnt_ff <= vcnt_in;
         perr_ff <= perr_in;
         eerr_ff <= eerr_in;
         drain_ff <= drain_in;
         rsp_v_ff <= rsp_v_in;
      end
      func_ff <= func_in;
      opc_ff <= opc_in;
      opnd_ff <= opnd_in;
      last_ff <= last_in;
      cur_ff <= cur_in;
      va_ff <= va_in;
      rsp_d_ff <= rsp_d_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_d_ff;

   a_ocnt_range: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= FULL) else $error("operator count beyond depth");
   a_vcnt_range: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= FULL) else $error("value count beyond depth");
   a_alu_idle: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> state_ff == S_WAIT) else $error("arithmetic result unexpected");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> ocnt_ff == '0 && vcnt_ff == '0) else $error("state not cleared");

endmodule

>>> dv/infix_expression_evaluator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top_test
// Streams infix token sequences into the evaluator, predicts each result with
// a behavioural shunting-yard model and checks value, truth and status.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top_test;

   localparam int DEPTH = iee_pkg::STACK_DEPTH_DEF;
   localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  op_code;
      logic [63:0] operand;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [63:0] value;
      logic        truth;
      logic [2:0]  status;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   infix_expression_evaluator_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   token_type   pending_tokens[$];
   outcome_type expected_outcomes[$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          tokens_sent = 0;
   longint      cycle_count = 0;
   bit          quiet = 1'b0;
   bit          stim_done = 1'b0;

   // evaluator state
   logic [4:0]  op_stack[DEPTH];
   logic [63:0] val_stack[DEPTH];
   int          op_cnt = 0;
   int          val_cnt = 0;
   logic [2:0]  parse_err = iee_pkg::ST_OK;
   logic [2:0]  eval_err = iee_pkg::ST_OK;

   function automatic int precedence(logic [4:0] op);
      if (op >= 2 && op <= 4) return 5;
      if (op <= 1) return 4;
      if (op >= 5 && op <= 8) return 3;
      if (op == 9 || op == 10) return 2;
      if (op == 11 || op == 12) return 1;
      return 0;
   endfunction

   task automatic apply_operator(logic [4:0] op);
      logic [63:0] a, b, r, ma, mb, q;
      logic lt, eq;
      if (eval_err != iee_pkg::ST_OK) return;
      if (val_cnt < 2) begin
         eval_err = iee_pkg::ST_INVALID;
         return;
      end
      a = val_stack[val_cnt-2];
      b = val_stack[val_cnt-1];
      lt = $signed(a) < $signed(b);
      eq = (a == b);
      r = '0;
      case (op[3:0])
         iee_pkg::OP_ADD: r = a + b;
         iee_pkg::OP_SUB: r = a - b;
         iee_pkg::OP_MUL: r = a * b;
         iee_pkg::OP_DIV, iee_pkg::OP_MOD: begin
            if (b == 0) begin
               eval_err = iee_pkg::ST_DIV0;
               return;
            end
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            if (op[3:0] == iee_pkg::OP_DIV) begin
               q = ma / mb;
               r = (a[63] ^ b[63]) ? -q : q;
            end else begin
               q = ma % mb;
               r = a[63] ? -q : q;
            end
         end
         iee_pkg::OP_GT: r = {63'd0, !lt && !eq};
         iee_pkg::OP_GE: r = {63'd0, !lt};
         iee_pkg::OP_LT: r = {63'd0, lt};
         iee_pkg::OP_LE: r = {63'd0, lt || eq};
         iee_pkg::OP_EQ: r = {63'd0, eq};
         iee_pkg::OP_NE: r = {63'd0, !eq};
         iee_pkg::OP_OR: r = {63'd0, a != 0 || b != 0};
         default: r = {63'd0, a != 0 && b != 0};
      endcase
      val_cnt--;
      val_stack[val_cnt-1] = r;
   endtask

   task automatic predict_token(token_type t);
      outcome_type o;
      logic [2:0] st;
      if (parse_err == iee_pkg::ST_OK) begin
         case (t.func)
            iee_pkg::FUNC_OPERAND: begin
               if (eval_err == iee_pkg::ST_OK) begin
                  if (val_cnt >= DEPTH) eval_err = iee_pkg::ST_OVERFLOW;
                  else val_stack[val_cnt++] = t.operand;
               end
            end
            iee_pkg::FUNC_OPERATOR: begin
               if (t.op_code > iee_pkg::OP_AND) parse_err = iee_pkg::ST_INVALID;
               else begin
                  while (op_cnt > 0 && op_stack[op_cnt-1] != iee_pkg::OPEN_MARK &&
                         precedence(op_stack[op_cnt-1]) >= precedence({1'b0, t.op_code})) begin
                     op_cnt--;
                     apply_operator(op_stack[op_cnt]);
                  end
                  if (op_cnt >= DEPTH) parse_err = iee_pkg::ST_OVERFLOW;
                  else op_stack[op_cnt++] = {1'b0, t.op_code};
               end
            end
            iee_pkg::FUNC_OPEN: begin
               if (op_cnt >= DEPTH) parse_err = iee_pkg::ST_OVERFLOW;
               else op_stack[op_cnt++] = iee_pkg::OPEN_MARK;
            end
            iee_pkg::FUNC_CLOSE: begin
               while (op_cnt > 0 && op_stack[op_cnt-1] != iee_pkg::OPEN_MARK) begin
                  op_cnt--;
                  apply_operator(op_stack[op_cnt]);
               end
               if (op_cnt == 0) parse_err = iee_pkg::ST_PAREN;
               else op_cnt--;
            end
            default: parse_err = iee_pkg::ST_INVALID;
         endcase
      end
      if (!t.last) return;
      while (parse_err == iee_pkg::ST_OK && op_cnt > 0) begin
         if (op_stack[op_cnt-1] == iee_pkg::OPEN_MARK) parse_err = iee_pkg::ST_PAREN;
         else begin
            op_cnt--;
            apply_operator(op_stack[op_cnt]);
         end
      end
      if (parse_err == iee_pkg::ST_OK && eval_err == iee_pkg::ST_OK && val_cnt != 1)
         eval_err = iee_pkg::ST_INVALID;
      st = (parse_err != iee_pkg::ST_OK) ? parse_err : eval_err;
      o.status = st;
      o.value = (st == iee_pkg::ST_OK) ? val_stack[0] : '0;
      o.truth = (o.value != 0);
      expected_outcomes.push_back(o);
      op_cnt = 0;
      val_cnt = 0;
      parse_err = iee_pkg::ST_OK;
      eval_err = iee_pkg::ST_OK;
   endtask

   // ---- stimulus builders
   function automatic token_type mk(logic [2:0] f, logic [3:0] op, logic [63:0] v, bit l);
      token_type t;
      t.func = f;
      t.op_code = op;
      t.operand = v;
      t.last = l;
      return t;
   endfunction

   function automatic logic [63:0] rand_value();
      case ($urandom_range(0, 7))
         0: return MIN_VAL;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return 64'hffff_ffff_ffff_ffff;
         3: return 64'd0;
         4: return {$urandom, $urandom};
         default: return 64'($signed($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   task automatic push_binary(logic [63:0] a, logic [3:0] op, logic [63:0] b);
      pending_tokens.push_back(mk(iee_pkg::FUNC_OPERAND, 4'($urandom), a, 1'b0));
      pending_tokens.push_back(mk(iee_pkg::FUNC_OPERATOR, op, {$urandom, $urandom}, 1'b0));
      pending_tokens.push_back(mk(iee_pkg::FUNC_OPERAND, 4'($urandom), b, 1'b1));
   endtask

   // well-formed expression with random nesting
   task automatic gen_expression(int terms, int depth_lim);
      int opens = 0;
      for (int i = 0; i < terms; i++) begin
         while (opens < depth_lim && $urandom_range(0, 3) == 0) begin
            pending_tokens.push_back(mk(iee_pkg::FUNC_OPEN, 4'($urandom),
                                        {$urandom, $urandom}, 1'b0));
            opens++;
         end
         pending_tokens.push_back(mk(iee_pkg::FUNC_OPERAND, 4'($urandom), rand_value(), 1'b0));
         while (opens > 0 && $urandom_range(0, 2) == 0) begin
            pending_tokens.push_back(mk(iee_pkg::FUNC_CLOSE, 4'($urandom),
                                        {$urandom, $urandom}, 1'b0));
            opens--;
         end
         if (i != terms - 1)
            pending_tokens.push_back(mk(iee_pkg::FUNC_OPERATOR, 4'($urandom_range(0, 12)),
                                        {$urandom, $urandom}, 1'b0));
      end
      while (opens > 0) begin
         pending_tokens.push_back(mk(iee_pkg::FUNC_CLOSE, 4'($urandom),
                                     {$urandom, $urandom}, 1'b0));
         opens--;
      end
   endtask

   task automatic mark_last();
      token_type t;
      t = pending_tokens.pop_back();
      t.last = 1'b1;
      pending_tokens.push_back(t);
   endtask

   task automatic build_stimulus();
      token_type t;
      // directed: every operator, extremes, special cases
      for (int op = 0; op <= 12; op++) push_binary(-64'sd7, op[3:0], 64'd3);
      push_binary(MIN_VAL, iee_pkg::OP_DIV, 64'hffff_ffff_ffff_ffff);
      push_binary(MIN_VAL, iee_pkg::OP_MOD, 64'hffff_ffff_ffff_ffff);
      push_binary(64'd5, iee_pkg::OP_DIV, 64'd0);
      push_binary(64'h7fff_ffff_ffff_ffff, iee_pkg::OP_MUL, MIN_VAL);
      // unmatched close
      pending_tokens.push_back(mk(iee_pkg::FUNC_CLOSE, 4'd0, 64'd0, 1'b1));
      pending_tokens.push_back(mk(iee_pkg::FUNC_OPEN, 4'd0, 64'd0, 1'b0));
      // open left over
      pending_tokens.push_back(mk(iee_pkg::FUNC_OPERAND, 4'd0, 64'd1, 1'b1));
      // invalid kind
      pending_tokens.push_back(mk(3'd7, 4'hf, '1, 1'b1));
      // invalid op code
      pending_tokens.push_back(mk(iee_pkg::FUNC_OPERATOR, 4'd15, 64'd0, 1'b1));
      // too few values
      pending_tokens.push_back(mk(iee_pkg::FUNC_OPERATOR, iee_pkg::OP_ADD, 64'd0, 1'b1));
      // division by zero then a paren error: parse error wins
      push_binary(64'd1, iee_pkg::OP_MOD, 64'd0);
      t = pending_tokens.pop_back();
      t.last = 1'b0;
      pending_tokens.push_back(t);
      pending_tokens.push_back(mk(iee_pkg::FUNC_CLOSE, 4'd0, 64'd0, 1'b1));
      // operator stack overflow
      for (int i = 0; i <= DEPTH; i++)
         pending_tokens.push_back(mk(iee_pkg::FUNC_OPEN, 4'd0, 64'd0, 1'b0));
      pending_tokens.push_back(mk(iee_pkg::FUNC_OPERAND, 4'd0, 64'd2, 1'b1));
      // value stack overflow
      for (int i = 0; i <= DEPTH; i++)
         pending_tokens.push_back(mk(iee_pkg::FUNC_OPERAND, 4'd0, 64'(i), 1'b0));
      pending_tokens.push_back(mk(iee_pkg::FUNC_OPERAND, 4'd0, 64'd9, 1'b1));
      // random part
      while (pending_tokens.size() < 1250) begin
         if ($urandom_range(0, 9) < 8) begin
            gen_expression($urandom_range(1, 8), $urandom_range(0, 3));
         end else begin
            repeat ($urandom_range(1, 6))
               pending_tokens.push_back(mk(3'($urandom_range(0, 7)), 4'($urandom),
                                           rand_value(), 1'b0));
         end
         mark_last();
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
   endtask

   // ---- driver
   int  send_gap = 0;
   int  recv_gap = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) tokens_sent++;
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 16);
               req_tvalid <= 1'b0;
            end else if (pending_tokens.size() > 0) begin
               token_type t;
               t = pending_tokens.pop_front();
               predict_token(t);
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, t.operand, t.op_code, t.func};
               req_tlast <= t.last;
            end else begin
               req_tvalid <= 1'b0;
               stim_done <= 1'b1;
            end
         end
         // receiver stalls
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---- monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         outcome_type o;
         results_seen++;
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[63:0], 64'd0);
         end else begin
            o = expected_outcomes.pop_front();
            if (rsp_tdata[63:0] !== o.value) report_mismatch("value", rsp_tdata[63:0], o.value);
            if (rsp_tdata[64] !== o.truth)
               report_mismatch("truth", 64'(rsp_tdata[64]), 64'(o.truth));
            if (rsp_tdata[67:65] !== o.status)
               report_mismatch("status", 64'(rsp_tdata[67:65]), 64'(o.status));
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_tokens.size() < 150);
      quiet = 1'b1;
   end

   initial begin
      wait (stim_done && expected_outcomes.size() == 0);
      repeat (300) @(posedge clock);
      $display("covered %0d tokens and %0d results across all operators, paren and",
               tokens_sent, results_seen);
      $display("stack-limit cases, with random stalls on both channels");
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // worst case: ~1250 tokens, deep drains of div ops, plus stalls
   initial begin
      wait (cycle_count > 2000000);
      $display("timeout with %0d results outstanding", expected_outcomes.size());
      $display("status: fail");
      $finish;
   end

endmodule
